[hw/rtl/log5_pkg.sv]
package log5_pkg;

   // line store depth, also the widest line the block takes
   localparam int MAX_WIDTH = 2048;
   localparam int COL_W = $clog2(MAX_WIDTH);

   localparam int PIX_W = 8;
   localparam int RESP_W = 13;
   localparam int DIM_W = 12;
   // width that holds both a line length and a clamped register value
   localparam int WCMP_W = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;

   localparam int TAPS = 5;
   localparam int COLUMN_W = TAPS * PIX_W;
   localparam int LINE_W = (TAPS - 1) * PIX_W;

   localparam int MIN_DIM = 5;
   localparam int MAX_HEIGHT = 4095;
   localparam int EDGE = 2;
   localparam int WIDTH_RESET = 640;
   localparam int HEIGHT_RESET = 480;

   localparam int CENTRE_SHIFT = 4;   // centre weight 16
   localparam int N1_W = PIX_W + 2;   // four taps
   localparam int N2_W = PIX_W + 3;   // eight taps

   localparam int CSR_IDX_W = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IMAGE_WIDTH,
      REG_IMAGE_HEIGHT
   } csr_reg_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             flush;
   } req_type;

   typedef struct packed {
      logic signed [RESP_W-1:0] response;
      logic [PIX_W-1:0]         pixel_out;
      logic                     is_border;
      logic                     last;
   } rsp_type;

   // window[k] holds column k (0 = newest), byte r is line r (0 = newest)
   typedef logic [TAPS-1:0][COLUMN_W-1:0] window_type;

   typedef struct packed {
      logic             advance;
      logic             rd_en;
      logic [COL_W-1:0] rd_col;
      logic             wr_en;
      logic [COL_W-1:0] wr_col;
      logic [PIX_W-1:0] wr_pixel;
   } win_ctrl_type;

   typedef struct packed {
      logic signed [RESP_W-1:0] response;
      logic [PIX_W-1:0]         saturated;
      logic [PIX_W-1:0]         centre;
   } kern_out_type;

endpackage

[hw/rtl/log5_window.sv]
// Line store and 5x5 window. Read issued with the request, write-back of
// the new column at the same column from the registered read data.
module log5_window (
   input  logic                  clock,
   input  logic                  reset,
   input  log5_pkg::win_ctrl_type ctrl,
   output log5_pkg::window_type  window
);

   logic [log5_pkg::LINE_W-1:0] line_mem [log5_pkg::MAX_WIDTH];
   logic [log5_pkg::LINE_W-1:0] rd_ff;
   logic [log5_pkg::COLUMN_W-1:0] column;
   log5_pkg::window_type win_ff;

   assign column = {rd_ff, ctrl.wr_pixel};

   // read data holds while the pipeline is held
   always_ff @(posedge clock) begin
      if (ctrl.advance && ctrl.rd_en) begin
         rd_ff <= line_mem[ctrl.rd_col];
      end
      if (ctrl.advance && ctrl.wr_en) begin
         line_mem[ctrl.wr_col] <= column[log5_pkg::LINE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (ctrl.advance && ctrl.wr_en) begin
         for (int k = log5_pkg::TAPS - 1; k > 0; k--) begin
            win_ff[k] <= win_ff[k-1];
         end
         win_ff[0] <= column;
      end
   end

   assign window = win_ff;

endmodule

[hw/rtl/log5_kernel.sv]
// LoG kernel: partial sums registered, final combine and clip after.
module log5_kernel (
   input  logic                  clock,
   input  logic                  advance,
   input  log5_pkg::window_type  window,
   output log5_pkg::kern_out_type result
);

   logic [log5_pkg::N1_W-1:0]   n1_in, n1_ff;
   logic [log5_pkg::N2_W-1:0]   n2_in, n2_ff;
   logic [log5_pkg::PIX_W-1:0]  centre_in, centre_ff;
   logic signed [log5_pkg::RESP_W-1:0] resp;

   function automatic logic [log5_pkg::PIX_W-1:0] tap(log5_pkg::window_type w,
                                                       int k, int r);
      return w[k][r*log5_pkg::PIX_W +: log5_pkg::PIX_W];
   endfunction

   always_comb begin
      centre_in = tap(window, 2, 2);
      n1_in = log5_pkg::N1_W'(tap(window, 2, 3)) + log5_pkg::N1_W'(tap(window, 2, 1))
            + log5_pkg::N1_W'(tap(window, 3, 2)) + log5_pkg::N1_W'(tap(window, 1, 2));
      n2_in = log5_pkg::N2_W'(tap(window, 2, 4)) + log5_pkg::N2_W'(tap(window, 2, 0))
            + log5_pkg::N2_W'(tap(window, 4, 2)) + log5_pkg::N2_W'(tap(window, 0, 2))
            + log5_pkg::N2_W'(tap(window, 3, 3)) + log5_pkg::N2_W'(tap(window, 1, 3))
            + log5_pkg::N2_W'(tap(window, 3, 1)) + log5_pkg::N2_W'(tap(window, 1, 1));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         n1_ff <= n1_in;
         n2_ff <= n2_in;
         centre_ff <= centre_in;
      end
   end

   // true value fits 13 bits, so wrap-around arithmetic is exact
   always_comb begin
      resp = $signed((log5_pkg::RESP_W'(centre_ff) << log5_pkg::CENTRE_SHIFT)
                     - (log5_pkg::RESP_W'(n1_ff) << 1)
                     - log5_pkg::RESP_W'(n2_ff));
      result.response = resp;
      result.centre = centre_ff;
      if (resp[log5_pkg::RESP_W-1]) begin
         result.saturated = '0;
      end else if (resp[log5_pkg::RESP_W-2:log5_pkg::PIX_W] != '0) begin
         result.saturated = '1;
      end else begin
         result.saturated = resp[log5_pkg::PIX_W-1:0];
      end
   end

endmodule

[hw/rtl/log_5x5_edge_filter_core.sv]
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  log5_pkg::req_type {pixel, flush}
// rsp      out        rsp_valid/rsp_stall  log5_pkg::rsp_type
//                                          {response, pixel_out, is_border, last}
// csr      in         csr_valid/csr_ready  csr_index, csr_wdata (12 bit)
//
// One request per clock sustained while no result is stalled; the line store has one read and one write
// port and a request's read and write-back fall on different columns.
// A request's result passes the p1, p2 and p3 stages and the output register; the pixel at
// raster index n is answered by request n+2W+2.
// Synchronous reset clears counters, window and valids; no clearing pass, the
// line store starts undefined.
// rsp_stall with a result offered holds the whole pipeline; req_stall then rises in the same cycle.
module log_5x5_edge_filter_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  log5_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output log5_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [log5_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [log5_pkg::DIM_W-1:0]        csr_wdata
);

   localparam int WC = log5_pkg::WCMP_W;
   localparam int CW = log5_pkg::COL_W;
   localparam int DW = log5_pkg::DIM_W;

   // configuration
   logic [DW-1:0] width_ff, width_in;
   logic [DW-1:0] height_ff, height_in;
   logic [WC-1:0] eff_w, cfg_w_ext;
   logic [DW-1:0] eff_h;

   // frame position counters
   logic [CW-1:0] in_col_ff, in_col_in;
   logic [DW-1:0] in_row_ff, in_row_in;
   logic [CW-1:0] out_col_ff, out_col_in;
   logic [DW-1:0] out_row_ff, out_row_in;

   // request decode
   logic advance, take, live, tail, emit, border, last;
   logic csr_write;
   logic [WC-1:0] in_col_ext, in_col_inc, out_col_ext, out_col_inc;
   logic in_wrap, out_wrap;
   logic [log5_pkg::PIX_W-1:0] val;

   // pipeline: p1 line store read, p2 window loaded, p3 partial sums
   logic p1_valid_ff, p1_emit_ff, p1_border_ff, p1_last_ff;
   logic [CW-1:0] p1_col_ff;
   logic [log5_pkg::PIX_W-1:0] p1_val_ff;
   logic p2_valid_ff, p2_border_ff, p2_last_ff;
   logic p3_valid_ff, p3_border_ff, p3_last_ff;

   logic rsp_valid_ff;
   log5_pkg::rsp_type rsp_data_ff, rsp_data_in;

   log5_pkg::win_ctrl_type win_ctrl;
   log5_pkg::window_type   window;
   log5_pkg::kern_out_type kern;

   // whole pipeline moves unless a result is held at the output
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = reset || !advance;
   assign take      = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // registers used clamped
   always_comb begin
      cfg_w_ext = WC'(width_ff);
      if (cfg_w_ext < WC'(log5_pkg::MIN_DIM)) begin
         eff_w = WC'(log5_pkg::MIN_DIM);
      end else if (cfg_w_ext > WC'(log5_pkg::MAX_WIDTH)) begin
         eff_w = WC'(log5_pkg::MAX_WIDTH);
      end else begin
         eff_w = cfg_w_ext;
      end
      if (height_ff < DW'(log5_pkg::MIN_DIM)) begin
         eff_h = DW'(log5_pkg::MIN_DIM);
      end else if (32'(height_ff) > log5_pkg::MAX_HEIGHT) begin
         eff_h = DW'(log5_pkg::MAX_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
   end

   always_comb begin
      tail = in_row_ff >= eff_h;
      // a flush before the tail phase is swallowed
      live = take && (tail || !req_data.flush);
      val  = tail ? '0 : req_data.pixel;

      in_col_ext  = WC'(in_col_ff);
      in_col_inc  = in_col_ext + WC'(1);
      in_wrap     = in_col_inc >= eff_w;
      out_col_ext = WC'(out_col_ff);
      out_col_inc = out_col_ext + WC'(1);
      out_wrap    = out_col_inc >= eff_w;

      emit = tail || (in_row_ff > DW'(log5_pkg::EDGE))
           || (in_row_ff == DW'(log5_pkg::EDGE) && in_col_ext >= WC'(log5_pkg::EDGE));
      border = (out_row_ff < DW'(log5_pkg::EDGE))
             || (out_row_ff >= eff_h - DW'(log5_pkg::EDGE))
             || (out_col_ext < WC'(log5_pkg::EDGE))
             || (out_col_ext >= eff_w - WC'(log5_pkg::EDGE));
      last = (out_row_ff == eff_h - DW'(1)) && (out_col_ext == eff_w - WC'(1));
   end

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (csr_write) begin
         // any register write restarts the frame
         case (csr_index)
            log5_pkg::REG_IMAGE_WIDTH:  width_in = csr_wdata;
            log5_pkg::REG_IMAGE_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (live) begin
         in_col_in = in_wrap ? '0 : in_col_inc[CW-1:0];
         if (in_wrap && !tail) begin
            in_row_in = in_row_ff + DW'(1);
         end
         if (emit) begin
            out_col_in = out_wrap ? '0 : out_col_inc[CW-1:0];
            if (out_wrap) begin
               out_row_in = out_row_ff + DW'(1);
            end
            if (last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= DW'(log5_pkg::WIDTH_RESET);
         height_ff  <= DW'(log5_pkg::HEIGHT_RESET);
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // control valids
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff  <= live;
         p2_valid_ff  <= p1_valid_ff && p1_emit_ff;
         p3_valid_ff  <= p2_valid_ff;
         rsp_valid_ff <= p3_valid_ff;
      end
   end

   // payload along the pipeline
   always_ff @(posedge clock) begin
      if (advance) begin
         p1_emit_ff   <= emit;
         p1_border_ff <= border;
         p1_last_ff   <= last;
         p1_col_ff    <= in_col_ff;
         p1_val_ff    <= val;
         p2_border_ff <= p1_border_ff;
         p2_last_ff   <= p1_last_ff;
         p3_border_ff <= p2_border_ff;
         p3_last_ff   <= p2_last_ff;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   // read for the new request, write-back for the one in p1; the two columns
   // always differ since a line is at least five pixels long
   always_comb begin
      win_ctrl.advance  = advance;
      win_ctrl.rd_en    = live;
      win_ctrl.rd_col   = in_col_ff;
      win_ctrl.wr_en    = p1_valid_ff;
      win_ctrl.wr_col   = p1_col_ff;
      win_ctrl.wr_pixel = p1_val_ff;
   end

   log5_window u_window (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (win_ctrl),
      .window (window)
   );

   log5_kernel u_kernel (
      .clock   (clock),
      .advance (advance),
      .window  (window),
      .result  (kern)
   );

   // border pixels pass through with a zero response
   always_comb begin
      rsp_data_in.response  = p3_border_ff ? '0 : kern.response;
      rsp_data_in.pixel_out = p3_border_ff ? kern.centre : kern.saturated;
      rsp_data_in.is_border = p3_border_ff;
      rsp_data_in.last      = p3_last_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hw/rtl/log5_checker.sv]
module log5_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input log5_pkg::rsp_type rsp_data
);

   // a held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // the input is only held back by a stalled result
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without output back-pressure");

   a_border_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_border |-> rsp_data.response == '0)
      else $error("border result with non-zero response");

   a_neg_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_border && rsp_data.response[log5_pkg::RESP_W-1]
      |-> rsp_data.pixel_out == '0)
      else $error("negative response not clipped to zero");

   a_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_border && !rsp_data.response[log5_pkg::RESP_W-1]
      && rsp_data.response[log5_pkg::RESP_W-2:log5_pkg::PIX_W] == '0
      |-> rsp_data.pixel_out == rsp_data.response[log5_pkg::PIX_W-1:0])
      else $error("in-range response not passed to pixel_out");

endmodule

bind log_5x5_edge_filter_core log5_checker u_log5_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[dv/log_5x5_edge_filter_core_test.sv]
`timescale 1ns / 100ps

module log_5x5_edge_filter_core_test;
   import log5_pkg::*;

   // longest run of cycles with no request, result or register write moving;
   // the hold-off below is the longest legitimate stretch
   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_ITEMS = 450;

   // kinds of picture content for the random frames
   typedef enum int {
      FILL_NOISE,          // uniform 0..255
      FILL_SPARSE_BRIGHT,  // mostly black, odd white dots: large positive responses
      FILL_SPARSE_DARK,    // mostly white, odd black dots: large negative responses
      FILL_FAINT           // low values, responses often inside 0..255
   } fill_kind_type;

   // Predicts the filter output from the requests it is told about and
   // checks the block's results against it in order.
   class log_response_tracker_type;
      bit [DIM_W-1:0]    width_reg;
      bit [DIM_W-1:0]    height_reg;
      bit [LINE_W-1:0]   line_mem [MAX_WIDTH];
      bit [COLUMN_W-1:0] win [TAPS];
      int unsigned       in_col, in_row, out_col, out_row;
      rsp_type           pending_responses [$];
      int unsigned       results_seen;
      int                fail_count;

      function new();
         width_reg = DIM_W'(WIDTH_RESET);
         height_reg = DIM_W'(HEIGHT_RESET);
      endfunction

      function int unsigned frame_width();
         int unsigned w;
         w = width_reg;
         if (w < MIN_DIM) w = MIN_DIM;
         if (w > MAX_WIDTH) w = MAX_WIDTH;
         return w;
      endfunction

      function int unsigned frame_height();
         int unsigned h;
         h = height_reg;
         if (h < MIN_DIM) h = MIN_DIM;
         if (h > MAX_HEIGHT) h = MAX_HEIGHT;
         return h;
      endfunction

      function void restart();
         in_col = 0;
         in_row = 0;
         out_col = 0;
         out_row = 0;
      endfunction

      // a write restarts the frame; line store and window keep their contents
      function void write_register(csr_reg_type idx, bit [DIM_W-1:0] value);
         case (idx)
            REG_IMAGE_WIDTH: width_reg = value;
            REG_IMAGE_HEIGHT: height_reg = value;
            default: ;
         endcase
         restart();
      endfunction

      // window column k (0 = newest), line r (0 = newest)
      function int tap(int k, int r);
         return int'(win[k][PIX_W*r +: PIX_W]);
      endfunction

      function void note_request(req_type item);
         int unsigned w, h, col;
         bit tail, emit, border, last;
         bit [PIX_W-1:0] val;
         bit [COLUMN_W-1:0] column;
         int resp, pout;
         rsp_type want;
         w = frame_width();
         h = frame_height();
         tail = (in_row >= h);
         // a flush before the tail is simply dropped
         if (!tail && item.flush) return;
         // in the tail any request pushes a blank pixel
         val = tail ? '0 : item.pixel;
         if (in_col >= w) in_col = 0;
         col = in_col;
         column = {line_mem[col], val};
         line_mem[col] = column[LINE_W-1:0];
         for (int k = TAPS - 1; k > 0; k--) win[k] = win[k-1];
         win[0] = column;
         emit = tail || in_row > EDGE || (in_row == EDGE && in_col >= EDGE);
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            if (in_row < h) in_row++;
         end
         if (!emit) return;

         border = out_row < EDGE || out_row >= h - EDGE ||
                  out_col < EDGE || out_col >= w - EDGE;
         if (border) begin
            resp = 0;
            pout = tap(2, 2);
         end else begin
            resp = (tap(2, 2) << CENTRE_SHIFT)
                 - tap(2, 4) - tap(2, 0) - tap(4, 2) - tap(0, 2)
                 - 2 * (tap(2, 3) + tap(2, 1) + tap(3, 2) + tap(1, 2))
                 - tap(3, 3) - tap(1, 3) - tap(3, 1) - tap(1, 1);
            pout = (resp < 0) ? 0 : ((resp > 255) ? 255 : resp);
         end
         last = (out_row == h - 1) && (out_col == w - 1);

         want.response = resp[RESP_W-1:0];
         want.pixel_out = pout[PIX_W-1:0];
         want.is_border = border;
         want.last = last;
         pending_responses.push_back(want);

         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
         if (last) restart();
      endfunction

      task report(string msg);
         fail_count++;
         if (fail_count <= 40) $display("tb: mismatch: %s", msg);
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         results_seen++;
         if (pending_responses.size() == 0) begin
            report($sformatf("result %0d arrived with none expected", results_seen));
            return;
         end
         want = pending_responses.pop_front();
         if (got.response !== want.response)
            report($sformatf("result %0d response %0d, expected %0d",
                             results_seen, got.response, want.response));
         if (got.pixel_out !== want.pixel_out)
            report($sformatf("result %0d pixel_out %0d, expected %0d",
                             results_seen, got.pixel_out, want.pixel_out));
         if (got.is_border !== want.is_border)
            report($sformatf("result %0d is_border %b, expected %b",
                             results_seen, got.is_border, want.is_border));
         if (got.last !== want.last)
            report($sformatf("result %0d last %b, expected %b",
                             results_seen, got.last, want.last));
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DIM_W-1:0]     csr_wdata = '0;

   // idling odds per cycle, in percent
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   // raised by the stimulus to start one long hold-off on the result side
   bit hold_req = 1'b0;
   int hold_left = 0;
   int unsigned items_sent = 0;
   int quiet_cycles = 0;

   log_response_tracker_type tracker = new();

   log_5x5_edge_filter_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // Result side: take what the block offers, then pick the next stall.
   // Everything is sampled at the edge, before the block's own updates land.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_result(rsp_data);
      if (hold_req) begin
         hold_req = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         // long hold-off: the block must fill up and stall its requests
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Watchdog: a stretch with nothing moving on any channel means a hang.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Offer one request, idling first at random, and wait until it is taken.
   // valid stays high on return so the next request can follow in the same
   // edge; whoever stops sending lowers it.
   task automatic push_request(input logic [PIX_W-1:0] pixel, input logic flush);
      req_type item;
      int gap;
      item.pixel = pixel;
      item.flush = flush;
      gap = 0;
      while (gap < 30 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      tracker.note_request(item);
   endtask

   // Stop sending, let every expected result out, then let the pipeline run
   // unstalled to finish requests that give no result.
   task automatic wait_block_idle();
      int unstalled;
      unstalled = 0;
      req_valid <= 1'b0;
      while (tracker.pending_responses.size() != 0) @(posedge clock);
      while (unstalled < 8) begin
         @(posedge clock);
         if (!rsp_stall) unstalled++;
      end
   endtask

   // Write both size registers back to back, in random order.
   task automatic set_frame_size(input logic [DIM_W-1:0] width_value,
                                 input logic [DIM_W-1:0] height_value);
      csr_reg_type      index_list [2];
      logic [DIM_W-1:0] value_list [2];
      bit               height_first;
      height_first = $urandom_range(1);
      index_list[0] = height_first ? REG_IMAGE_HEIGHT : REG_IMAGE_WIDTH;
      index_list[1] = height_first ? REG_IMAGE_WIDTH : REG_IMAGE_HEIGHT;
      value_list[0] = height_first ? height_value : width_value;
      value_list[1] = height_first ? width_value : height_value;
      for (int i = 0; i < 2; i++) begin
         csr_valid <= 1'b1;
         csr_index <= index_list[i];
         csr_wdata <= value_list[i];
         do @(posedge clock); while (csr_ready !== 1'b1);
         tracker.write_register(index_list[i], value_list[i]);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [PIX_W-1:0] pick_pixel(fill_kind_type fill);
      case (fill)
         FILL_SPARSE_BRIGHT: return ($urandom_range(9) == 0) ? 8'hFF : 8'h00;
         FILL_SPARSE_DARK: return ($urandom_range(9) == 0) ? 8'h00 : 8'hFF;
         FILL_FAINT: return PIX_W'($urandom_range(15));
         default: return PIX_W'($urandom_range(255));
      endcase
   endfunction

   // Send pixel_count pixels of a frame from its start, with the odd stray
   // flush in between (ignored by the block, not counted), and if asked the
   // 2W+2 tail requests, a random mix of flushes and pixels that get dropped.
   task automatic send_frame(input fill_kind_type fill, input int unsigned pixel_count,
                             input bit with_tail);
      int unsigned tail_len;
      for (int unsigned n = 0; n < pixel_count; n++) begin
         if ($urandom_range(24) == 0) push_request(pick_pixel(fill), 1'b1);
         push_request(pick_pixel(fill), 1'b0);
         items_sent++;
      end
      if (with_tail) begin
         tail_len = 2 * tracker.frame_width() + 2;
         repeat (tail_len) begin
            push_request(PIX_W'($urandom_range(255)), 1'($urandom_range(1)));
            items_sent++;
         end
      end
   endtask

   initial begin
      int unsigned   wv, hv, frame_pixels;
      int            ring_dist;
      bit            frame_open;
      bit            pressure_done;
      logic [PIX_W-1:0] px;
      fill_kind_type fill;
      frame_open = 1'b0;
      pressure_done = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset sizes (640 x 480): a short run well inside the first 2W+2
      // requests, which must give no result at all.
      send_idle_pct = 23;
      recv_idle_pct = 56;
      send_frame(FILL_NOISE, 40, 1'b0);
      wait_block_idle();

      // Directed 5x5 frame, sizes given below the minimum so both clamp.
      // Centre white, all weighted taps black: the largest positive response.
      // Zero-weight corners carry assorted values; they only reach the output
      // as border pass-through. A flush mid-frame must be ignored, and in the
      // tail the white pixels offered must be dropped.
      set_frame_size('0, DIM_W'(MIN_DIM - 1));
      for (int r = 0; r < MIN_DIM; r++) begin
         for (int c = 0; c < MIN_DIM; c++) begin
            ring_dist = ((r > EDGE) ? r - EDGE : EDGE - r)
                      + ((c > EDGE) ? c - EDGE : EDGE - c);
            if (r == EDGE && c == EDGE)
               px = 8'hFF;
            else if (ring_dist <= EDGE)
               px = 8'h00;
            else
               px = PIX_W'((r * MIN_DIM + c) * 17);
            if (r * MIN_DIM + c == 7) push_request(8'hFF, 1'b1);
            push_request(px, 1'b0);
         end
      end
      for (int n = 0; n < 2 * MIN_DIM + 2; n++) push_request(8'hFF, 1'(n));

      // Random frames of small sizes. Most run to the end; some are cut off
      // and the next size write restarts mid-frame. Without a new size the
      // next frame follows straight on. Idling changes by thirds.
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent < RANDOM_ITEMS / 3) begin
            send_idle_pct = 23;
            recv_idle_pct = 56;
         end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 56;
            recv_idle_pct = 23;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (frame_open || $urandom_range(2) != 0) begin
            wait_block_idle();
            wv = ($urandom_range(7) == 0) ? $urandom_range(MIN_DIM - 1)
                                          : $urandom_range(MIN_DIM, 12);
            hv = ($urandom_range(7) == 0) ? $urandom_range(MIN_DIM - 1)
                                          : $urandom_range(MIN_DIM, 9);
            set_frame_size(DIM_W'(wv), DIM_W'(hv));
         end
         if (!pressure_done && items_sent >= 120) begin
            hold_req = 1'b1;
            pressure_done = 1'b1;
         end
         fill = fill_kind_type'($urandom_range(3));
         frame_pixels = tracker.frame_width() * tracker.frame_height();
         frame_open = ($urandom_range(7) == 0);
         if (frame_open)
            send_frame(fill, $urandom_range(1, frame_pixels - 1), 1'b0);
         else
            send_frame(fill, frame_pixels, 1'b1);
      end

      // Size extremes, no idling. Tallest frame (narrow, cut short: no early
      // end of frame), then the widest line from an over-range width write,
      // a short run that stays inside the first 2W+2 requests.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      wait_block_idle();
      set_frame_size(DIM_W'(MIN_DIM), '1);
      send_frame(FILL_NOISE, 30 * MIN_DIM, 1'b0);
      wait_block_idle();
      set_frame_size('1, DIM_W'(MIN_DIM));
      send_frame(FILL_SPARSE_DARK, 60, 1'b0);

      // drain, then keep running so anything unexpected can still show up
      req_valid <= 1'b0;
      while (tracker.pending_responses.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (tracker.fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
